/* rtl/ghu_pkg.sv */
// Shared types and constants for the Givens Hessenberg update block.
`timescale 1ns / 1ps
package ghu_pkg;
  localparam int MaxColumns = 32;
  localparam int IdxW = $clog2(MaxColumns);
  localparam logic [31:0] OneQ30 = 32'h4000_0000;

  typedef enum logic [0:0] {
    FUNC_START  = 1'b0,
    FUNC_COLUMN = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_CARRY,
    OP_ROTATE,
    OP_GEN,
    OP_ERROR
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ROT_M,
    ST_SQRT,
    ST_DIV,
    ST_RHS,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic start_decode;
    logic mul_step;
    logic sqrt_start;
    logic div_start;
    logic rhs_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic rhs_done;
    logic out_busy;
  } sts_t;
endpackage

/* rtl/ghu_ctrl.sv */
// Controller state machine sequencing the Givens update datapath.
`timescale 1ns / 1ps
module ghu_ctrl
  import ghu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts_i.op)
          OP_ROTATE: state_d = ST_ROT_M;
          OP_GEN:    state_d = ST_SQRT;
          OP_ERROR:  state_d = ST_OUT;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_ROT_M: begin
        if (sts_i.mul_done) state_d = ST_OUT;
      end
      ST_SQRT: begin
        if (sts_i.sqrt_done) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_RHS;
      end
      ST_RHS: begin
        if (sts_i.rhs_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.start_decode = 1'b1;
        cmd_o.sqrt_start = (sts_i.op == OP_GEN);
      end
      ST_ROT_M: cmd_o.mul_step = 1'b1;
      ST_SQRT: cmd_o.div_start = sts_i.sqrt_done;
      ST_DIV: cmd_o.rhs_step = 1'b0;
      ST_RHS: cmd_o.rhs_step = 1'b1;
      ST_OUT: cmd_o.out_load = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end
endmodule

/* rtl/ghu_dp.sv */
// Datapath: shared multiplier, square root and divider units, rotation store.
`timescale 1ns / 1ps
module ghu_dp
  import ghu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [0:0]  func_i,
  input  logic [31:0] value_i,
  input  logic        is_last_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [31:0] rotated_value_o,
  output logic [5:0]  row_index_o,
  output logic        column_done_o,
  output logic [31:0] rhs_value_o,
  output logic [30:0] residual_o,
  output logic        error_o
);
  logic [0:0]  func_q;
  logic signed [31:0] val_q;
  logic        last_q;
  logic signed [31:0] carry_q, carry_d;
  logic [5:0]  elem_q, elem_d;
  logic [5:0]  col_q, col_d;
  logic signed [31:0] pend_q, pend_d;
  op_e op;

  logic signed [31:0] cos_mem [MaxColumns];
  logic signed [31:0] sin_mem [MaxColumns];
  logic signed [31:0] rc_q, rs_q;

  // multiply sequencer
  logic [1:0] mstep_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] up_q;
  logic mul_run_q;

  // result fields
  logic signed [31:0] res_val_q;
  logic [5:0]  res_row_q;
  logic        res_done_q;
  logic signed [31:0] res_rhs_q;
  logic [30:0] res_resid_q;
  logic        res_err_q;

  // sqrt
  logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
  logic        sq_busy_q, sq_done_q;
  logic [1:0]  sq_phase_q;
  logic signed [63:0] sq_prod_q;
  logic signed [31:0] r_q;
  logic        zero_q;

  // divider: 62-bit magnitude by 31-bit, restoring, two quotients in turn
  logic [62:0] dv_num_q;
  logic [31:0] dv_rem_q;
  logic [62:0] dv_quo_q;
  logic [5:0]  dv_cnt_q;
  logic        dv_busy_q, dv_sel_q, dv_neg_q, dv_done_q;
  logic signed [31:0] gc_q, gs_q;

  // rhs multiply
  logic [1:0] rh_step_q;
  logic       rh_done_q;
  logic signed [31:0] fin_q;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fff_ffff;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [IdxW-1:0] idx_of(input logic [5:0] v);
    logic [5:0] m;
    m = v % 6'(MaxColumns);
    return m[IdxW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      val_q  <= value_i;
      last_q <= is_last_i;
    end
  end

  // decode of the held item
  always_comb begin
    op = OP_NONE;
    if (func_q == FUNC_START) begin
      op = OP_START;
    end else if (col_q >= 6'(MaxColumns)) begin
      op = OP_ERROR;
    end else if (last_q != (elem_q == col_q + 6'd1)) begin
      op = OP_ERROR;
    end else if (elem_q == 6'd0) begin
      op = OP_CARRY;
    end else if (!last_q) begin
      op = OP_ROTATE;
    end else begin
      op = OP_GEN;
    end
  end

  // rotation store read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in || cmd_i.start_decode) begin
      rc_q <= cos_mem[idx_of(elem_q - 6'd1)];
      rs_q <= sin_mem[idx_of(elem_q - 6'd1)];
    end
    if (dv_done_q) begin
      cos_mem[idx_of(col_q)] <= gc_q;
      sin_mem[idx_of(col_q)] <= gs_q;
    end
  end

  // shared multiplier: c*x, s*y, c*y, s*x; rhs: c*p, s*p
  always_comb begin
    ma = rc_q;
    mb = carry_q;
    if (rh_step_q != 2'd0 || cmd_i.rhs_step) begin
      ma = (rh_step_q == 2'd0) ? gc_q : gs_q;
      mb = pend_q;
    end else begin
      case (mstep_q)
        2'd0: begin ma = rc_q; mb = carry_q; end
        2'd1: begin ma = rs_q; mb = val_q; end
        2'd2: begin ma = rc_q; mb = val_q; end
        2'd3: begin ma = rs_q; mb = carry_q; end
        default: begin ma = rc_q; mb = carry_q; end
      endcase
    end
  end

  logic signed [64:0] up_sum, lo_sum, npr;
  assign up_sum = 65'(acc_q) + 65'(prod_q);
  assign lo_sum = 65'(acc_q) - 65'(prod_q);
  assign npr = -65'(prod_q);

  logic [2:0] mcnt_q;
  logic mul_done;
  assign mul_done = (mcnt_q == 3'd5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
      mstep_q <= '0;
      rh_step_q <= '0;
      rh_done_q <= 1'b0;
    end else begin
      rh_done_q <= cmd_i.rhs_step && !rh_done_q && (rh_step_q == 2'd2);
      if (cmd_i.mul_step && !mul_done) begin
        mcnt_q <= mcnt_q + 3'd1;
        if (mcnt_q < 3'd3) mstep_q <= mstep_q + 2'd1;
      end else if (!cmd_i.mul_step) begin
        mcnt_q <= '0;
        mstep_q <= '0;
      end
      if (cmd_i.rhs_step && !rh_done_q) begin
        rh_step_q <= (rh_step_q == 2'd2) ? 2'd0 : rh_step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (cmd_i.mul_step) begin
      case (mcnt_q)
        3'd1: acc_q <= prod_q;
        3'd2: up_q <= up_sum[63:0];
        3'd3: acc_q <= prod_q;
        default: ;
      endcase
    end
    if (cmd_i.rhs_step && rh_step_q == 2'd1) fin_q <= sat32(66'(prod_q >>> 30));
  end

  // square root: square both operands in turn, then one result bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_done_q <= 1'b0;
      sq_phase_q <= '0;
    end else begin
      sq_done_q <= !cmd_i.sqrt_start && sq_busy_q && (sq_phase_q == 2'd2)
                   && (sq_bit_q == 64'd0);
      if (cmd_i.sqrt_start) begin
        sq_busy_q <= 1'b1;
        sq_phase_q <= 2'd0;
      end else if (sq_busy_q) begin
        case (sq_phase_q)
          2'd0: sq_phase_q <= 2'd1;
          2'd1: sq_phase_q <= 2'd2;
          2'd2: if (sq_bit_q == 64'd0) sq_busy_q <= 1'b0;
          default: sq_phase_q <= 2'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sq_prod_q <= carry_q * carry_q;
      zero_q <= (val_q == 32'sd0);
    end else if (sq_busy_q) begin
      case (sq_phase_q)
        2'd0: begin
          sq_n_q <= sq_prod_q;
          sq_prod_q <= val_q * val_q;
        end
        2'd1: begin
          sq_n_q <= sq_n_q + sq_prod_q;
          sq_res_q <= '0;
          sq_bit_q <= 64'h4000_0000_0000_0000;
        end
        2'd2: begin
          if (sq_bit_q != 64'd0) begin
            if (sq_n_q >= sq_res_q + sq_bit_q) begin
              sq_n_q <= sq_n_q - (sq_res_q + sq_bit_q);
              sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
            end else begin
              sq_res_q <= sq_res_q >> 1;
            end
            sq_bit_q <= sq_bit_q >> 2;
          end else begin
            r_q <= zero_q ? carry_q
                 : ((sq_res_q > 64'd2147483647) ? 32'sh7fff_ffff : sq_res_q[31:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // divider: |num|*2^30 / r, sign restored, truncated toward zero
  logic [32:0] dv_trial;
  assign dv_trial = {dv_rem_q, dv_num_q[62]} - {1'b0, r_q};
  logic signed [31:0] dv_src;
  assign dv_src = dv_sel_q ? val_q : carry_q;
  logic [31:0] dv_mag;
  assign dv_mag = dv_src[31] ? 32'(-dv_src) : dv_src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_done_q <= 1'b0;
      dv_sel_q <= 1'b0;
      dv_cnt_q <= '0;
    end else begin
      dv_done_q <= cmd_i.div_start ? zero_q
                 : (dv_busy_q && dv_sel_q && (dv_cnt_q == 6'd63));
      if (cmd_i.div_start) begin
        dv_sel_q <= 1'b0;
        dv_busy_q <= !zero_q;
        dv_cnt_q <= '0;
      end else if (dv_busy_q) begin
        if (dv_cnt_q == 6'd63) begin
          dv_cnt_q <= '0;
          if (dv_sel_q) dv_busy_q <= 1'b0;
          dv_sel_q <= 1'b1;
        end else begin
          dv_cnt_q <= dv_cnt_q + 6'd1;
        end
      end
    end
  end

  // bit 62 of the scaled magnitude is always clear: start at bit 61
  logic [63:0] dv_mag_q30;
  assign dv_mag_q30 = {2'b0, dv_mag, 30'b0};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      gc_q <= OneQ30;
      gs_q <= '0;
    end
    if (dv_busy_q) begin
      if (dv_cnt_q == 6'd0) begin
        dv_num_q <= {dv_mag_q30[61:0], 1'b0};
        dv_rem_q <= '0;
        dv_quo_q <= '0;
        dv_neg_q <= dv_src[31];
      end else if (dv_cnt_q == 6'd63) begin
        if (dv_sel_q) gs_q <= dv_neg_q ? 32'(-dv_quo_q) : dv_quo_q[31:0];
        else gc_q <= dv_neg_q ? 32'(-dv_quo_q) : dv_quo_q[31:0];
      end else begin
        dv_num_q <= dv_num_q << 1;
        if (!dv_trial[32]) begin
          dv_rem_q <= dv_trial[31:0];
          dv_quo_q <= {dv_quo_q[61:0], 1'b1};
        end else begin
          dv_rem_q <= {dv_rem_q[30:0], dv_num_q[62]};
          dv_quo_q <= {dv_quo_q[61:0], 1'b0};
        end
      end
    end
  end

  // architectural state
  logic signed [31:0] np;
  logic [31:0] np_abs;
  assign np = sat32(66'(npr >>> 30));
  assign np_abs = np[31] ? 32'(-np) : np;

  always_comb begin
    carry_d = carry_q;
    elem_d = elem_q;
    col_d = col_q;
    pend_d = pend_q;
    if (cmd_i.start_decode) begin
      case (op)
        OP_START: begin pend_d = val_q; col_d = '0; elem_d = '0; end
        OP_CARRY: begin carry_d = val_q; elem_d = 6'd1; end
        OP_ERROR: if (col_q < 6'(MaxColumns)) elem_d = '0;
        default: ;
      endcase
    end
    if (cmd_i.mul_step && mcnt_q == 3'd4) begin
      carry_d = sat32(66'(lo_sum >>> 30));
      elem_d = elem_q + 6'd1;
    end
    if (cmd_i.rhs_step && rh_step_q == 2'd2) begin
      pend_d = np;
      col_d = col_q + 6'd1;
      elem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      elem_q <= '0;
      col_q <= '0;
      pend_q <= '0;
      m_valid_o <= 1'b0;
    end else begin
      carry_q <= carry_d;
      elem_q <= elem_d;
      col_q <= col_d;
      pend_q <= pend_d;
      if (cmd_i.out_load) m_valid_o <= 1'b1;
      else if (m_valid_o && m_ready_i) m_valid_o <= 1'b0;
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_decode) begin
      res_val_q <= '0;
      res_row_q <= '0;
      res_done_q <= 1'b0;
      res_rhs_q <= '0;
      res_resid_q <= '0;
      res_err_q <= (op == OP_ERROR);
    end
    if (cmd_i.mul_step && mcnt_q == 3'd4) begin
      res_val_q <= sat32(66'(up_q >>> 30));
      res_row_q <= elem_q - 6'd1;
    end
    if (cmd_i.rhs_step && rh_step_q == 2'd2) begin
      res_val_q <= r_q;
      res_row_q <= col_q;
      res_done_q <= 1'b1;
      res_rhs_q <= fin_q;
      res_resid_q <= (np_abs > 32'h7fff_ffff) ? 31'h7fff_ffff : np_abs[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rotated_value_o <= res_val_q;
      row_index_o <= res_row_q;
      column_done_o <= res_done_q;
      rhs_value_o <= res_rhs_q;
      residual_o <= res_resid_q;
      error_o <= res_err_q;
    end
  end

  assign sts_o.op = op;
  assign sts_o.mul_done = mul_done;
  assign sts_o.sqrt_done = sq_done_q;
  assign sts_o.div_done = dv_done_q;
  assign sts_o.rhs_done = rh_done_q;
  assign sts_o.out_busy = m_valid_o && !m_ready_i;
endmodule

/* rtl/givens_hessenberg_update.sv */
// Top level of the Givens Hessenberg least-squares update block.
// Input channel s_axis: tdata = value (bits 31:0), tuser = func, tlast = is_last.
// Output channel m_axis carries one result item per rotated entry or error.
// A start item loads beta and gives no result; the first element of a column
// only loads the carry and gives no result.
// A rotation takes four products through the one shared multiplier; a column
// end runs the bit-per-cycle square root (32 steps) and then the bit-serial
// divider twice, for cos and sin (62 steps each); a zero subdiagonal skips
// the divider.
// One item is in work at a time; the output register holds a result until
// taken, and the next item is accepted once the result is loaded there.
// When the receiver stalls with a result held and a new result is ready,
// the controller waits, so input tready stays low.
// Reset clears the column, element and carry state and the pending value;
// the rotation store is written before it is read and needs no clearing.
`timescale 1ns / 1ps
module givens_hessenberg_update
  import ghu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // value[31:0]
  input  logic         s_axis_tuser,   // func
  input  logic         s_axis_tlast,   // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rotated_value[31:0], row_index[37:32], rhs_value[69:38], residual[100:70]
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tuser,   // error
  output logic         m_axis_tlast    // column_done
);
  cmd_t cmd;
  sts_t sts;
  logic [31:0] rot, rhs;
  logic [5:0]  row;
  logic [30:0] res;

  ghu_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ghu_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .func_i(s_axis_tuser), .value_i(s_axis_tdata), .is_last_i(s_axis_tlast),
    .cmd_i(cmd), .sts_o(sts),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .rotated_value_o(rot), .row_index_o(row), .column_done_o(m_axis_tlast),
    .rhs_value_o(rhs), .residual_o(res), .error_o(m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, res, rhs, row, rot};
endmodule

/* rtl/ghu_checker.sv */
// Port-level checker for the Givens Hessenberg update block, bound to the top.
`timescale 1ns / 1ps
module ghu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("error item carries data");
  a_resid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[100:38] == '0)
    else $error("rhs fields set outside column end");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted during work");
endmodule

bind givens_hessenberg_update ghu_checker u_ghu_checker (.*);
